### design/vector_similarity_macros.svh
// assertion helpers used by the top design file
`ifndef VECTOR_SIMILARITY_MACROS_SVH
`define VECTOR_SIMILARITY_MACROS_SVH

`ifndef ASSERT_OFF
`define VS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define VS_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define VS_ASSERT(lbl, clk, rstn, prop, msg)
`define VS_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### design/vs_pkg.sv
package vs_pkg;

    localparam int LIMB_W    = 16;
    localparam int PROD_W    = 2 * LIMB_W;
    localparam int COS_W     = 16;
    localparam int KW        = $clog2(COS_W);
    localparam int COS_SHIFT = 30;

    localparam logic [COS_W-1:0] COS_ONE = 16'h8000;

    typedef struct packed {
        logic mul_en;
        logic sub;
    } t_alu_ctl;

endpackage

### design/vs_alu.sv
module vs_alu #(
    parameter int W = 120
) (
    input  logic                   i_clk,
    input  vs_pkg::t_alu_ctl       i_ctl,
    input  logic [vs_pkg::LIMB_W-1:0] i_mul_x,
    input  logic [vs_pkg::LIMB_W-1:0] i_mul_y,
    input  logic [W-1:0]           i_add_x,
    input  logic [W-1:0]           i_add_y,
    output logic [vs_pkg::PROD_W-1:0] o_prod,
    output logic [W-1:0]           o_sum,
    output logic                   o_carry
);
    import vs_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [W:0]        w_full;
    logic [W-1:0]      w_y;

    // product is registered before any add that uses it
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_mul_x * i_mul_y;
        end
    end

    // subtract as x + ~y + 1, carry out high means x >= y
    assign w_y    = i_ctl.sub ? ~i_add_y : i_add_y;
    assign w_full = {1'b0, i_add_x} + {1'b0, w_y} + (W+1)'(i_ctl.sub);

    assign o_prod  = r_prod;
    assign o_sum   = w_full[W-1:0];
    assign o_carry = w_full[W];

endmodule

### design/vs_out_reg.sv
module vs_out_reg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [vs_pkg::COS_W-1:0] i_cosine,
    input  logic [15:0]              i_mean,
    input  logic                     i_zero,
    input  logic                     i_ready,
    output logic                     o_valid,
    output logic                     o_space,
    output logic [vs_pkg::COS_W-1:0] o_cosine,
    output logic [15:0]              o_mean,
    output logic                     o_zero
);
    import vs_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic [COS_W-1:0] r_cosine;
    logic [15:0]      r_mean;
    logic             r_zero;

    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cosine <= i_cosine;
            r_mean   <= i_mean;
            r_zero   <= i_zero;
        end
    end

    assign o_valid  = r_valid;
    assign o_cosine = r_cosine;
    assign o_mean   = r_mean;
    assign o_zero   = r_zero;

endmodule

### design/vector_similarity.sv
// channel   | valid       | ready        | payload
// ----------+-------------+--------------+-------------------------------------------
// element   | i_in_valid  | o_in_ready   | i_weight_a, i_weight_b, i_last_element
// result    | o_out_valid | i_out_ready  | o_cosine, o_mean_abs_distance, o_zero_norm
//
// an element runs through states E1 to E4 on one shared 16x16 multiplier and adder; ready only when idle
// the closing element adds setup and result load, the two wide products taken limb by limb
// (NL = 16-bit limbs per accumulator, 3 by default), the 16 root bits and ABS_W (28 by
// default) bits of division; a zero norm skips products and root
// synchronous active-low reset clears the sequencer, accumulators and output valid
// a held result does not block new elements; only a second result waits for it
`include "vector_similarity_macros.svh"

module vector_similarity #(
    parameter int MAX_LENGTH  = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_weight_a,
    input  logic [15:0] i_weight_b,
    input  logic        i_last_element,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [vs_pkg::COS_W-1:0] o_cosine,
    output logic [15:0] o_mean_abs_distance,
    output logic        o_zero_norm
);
    import vs_pkg::*;

    localparam int LG    = $clog2(MAX_LENGTH);
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int ACC_W = 2 * LIMB_W + LG;
    localparam int ABS_W = LIMB_W + LG;
    localparam int NL    = (ACC_W + LIMB_W - 1) / LIMB_W;
    localparam int LIW   = $clog2(NL);
    localparam int PW    = 2 * ACC_W;
    localparam int QW    = PW + COS_W;
    localparam int SW    = PW + COS_SHIFT;
    localparam int TW    = PW + 2 * COS_W;
    localparam int DIW   = $clog2(ABS_W);
    localparam int MB    = (WEIGHT_BITS >= 16) ? 16 : WEIGHT_BITS;

    localparam logic [15:0]      WMASK   = 16'((64'd1 << MB) - 64'd1);
    localparam logic [CNT_W-1:0] MAXC    = CNT_W'(MAX_LENGTH);
    localparam logic [LIW-1:0]   L_TOP   = LIW'(NL - 1);
    localparam logic [DIW-1:0]   DI_TOP  = DIW'(ABS_W - 1);
    localparam logic [KW-1:0]    K_TOP   = KW'(COS_W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_E1   = 4'd1;
    localparam logic [3:0] S_E2   = 4'd2;
    localparam logic [3:0] S_E3   = 4'd3;
    localparam logic [3:0] S_E4   = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_PM   = 4'd6;
    localparam logic [3:0] S_PA   = 4'd7;
    localparam logic [3:0] S_C1   = 4'd8;
    localparam logic [3:0] S_C2   = 4'd9;
    localparam logic [3:0] S_C3   = 4'd10;
    localparam logic [3:0] S_C4   = 4'd11;
    localparam logic [3:0] S_DV   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]       r_state, n_state;
    logic [15:0]      r_wa, n_wa, r_wb, n_wb;
    logic             r_last, n_last;
    logic [ACC_W-1:0] r_dot, n_dot, r_na, n_na, r_nb, n_nb;
    logic [ABS_W-1:0] r_abs, n_abs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LIW-1:0]   r_li, n_li, r_lj, n_lj;
    logic             r_phase, n_phase;
    logic [TW-1:0]    r_acc, n_acc;
    logic [PW-1:0]    r_p, n_p;
    logic [SW-1:0]    r_d, n_d, r_s, n_s;
    logic [QW-1:0]    r_q, n_q;
    logic [TW-1:0]    r_t, n_t;
    logic [COS_W-1:0] r_c, n_c;
    logic [KW-1:0]    r_k, n_k;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [ABS_W-1:0] r_quo, n_quo;
    logic [DIW-1:0]   r_di, n_di;
    logic             r_zero, n_zero;

    t_alu_ctl            w_ctl;
    logic [LIMB_W-1:0]   w_mul_x, w_mul_y;
    logic [TW-1:0]       w_add_x, w_add_y, w_sum;
    logic                w_carry;
    logic [PROD_W-1:0]   w_prod;
    logic [NL*LIMB_W-1:0] w_mx_pad, w_my_pad;
    logic [LIW:0]        w_lsum;
    logic [15:0]         w_diff;
    logic [CNT_W:0]      w_rp;
    logic                w_space;
    logic                w_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = (r_state == S_OUT) && w_space;

    assign w_diff   = (r_wa >= r_wb) ? (r_wa - r_wb) : (r_wb - r_wa);
    assign w_mx_pad = (NL*LIMB_W)'(r_phase ? r_dot : r_na);
    assign w_my_pad = (NL*LIMB_W)'(r_phase ? r_dot : r_nb);
    assign w_lsum   = {1'b0, r_li} + {1'b0, r_lj};
    assign w_rp     = {r_rem, r_abs[r_di]};

    // operand selection for the shared multiplier and adder
    always_comb begin
        w_ctl   = '0;
        w_mul_x = r_wa;
        w_mul_y = r_wb;
        w_add_x = '0;
        w_add_y = '0;
        case (r_state)
            S_E1: begin
                w_ctl.mul_en = 1'b1;
                w_add_x = TW'(r_abs);
                w_add_y = TW'(w_diff);
            end
            S_E2: begin
                w_ctl.mul_en = 1'b1;
                w_mul_y = r_wa;
                w_add_x = TW'(r_dot);
                w_add_y = TW'(w_prod);
            end
            S_E3: begin
                w_ctl.mul_en = 1'b1;
                w_mul_x = r_wb;
                w_add_x = TW'(r_na);
                w_add_y = TW'(w_prod);
            end
            S_E4: begin
                w_add_x = TW'(r_nb);
                w_add_y = TW'(w_prod);
            end
            S_PM: begin
                w_ctl.mul_en = 1'b1;
                w_mul_x = w_mx_pad[r_li*LIMB_W +: LIMB_W];
                w_mul_y = w_my_pad[r_lj*LIMB_W +: LIMB_W];
            end
            S_PA: begin
                w_add_x = r_acc;
                w_add_y = TW'(w_prod) << {w_lsum, 4'b0000};
            end
            S_C1: begin
                // trial (c + 2^k)^2 * P built from c^2*P, c*P and P
                w_add_x = TW'(r_s);
                w_add_y = TW'(r_q) << ({1'b0, r_k} + (KW+1)'(1));
            end
            S_C2: begin
                w_add_x = r_t;
                w_add_y = TW'(r_p) << {r_k, 1'b0};
            end
            S_C3: begin
                w_ctl.sub = 1'b1;
                w_add_x = TW'(r_d);
                w_add_y = r_t;
            end
            S_C4: begin
                w_add_x = TW'(r_q);
                w_add_y = TW'(r_p) << r_k;
            end
            S_DV: begin
                w_ctl.sub = 1'b1;
                w_add_x = TW'(w_rp);
                w_add_y = TW'(r_cnt);
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_wa    = r_wa;
        n_wb    = r_wb;
        n_last  = r_last;
        n_dot   = r_dot;
        n_na    = r_na;
        n_nb    = r_nb;
        n_abs   = r_abs;
        n_cnt   = r_cnt;
        n_li    = r_li;
        n_lj    = r_lj;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_p     = r_p;
        n_d     = r_d;
        n_s     = r_s;
        n_q     = r_q;
        n_t     = r_t;
        n_c     = r_c;
        n_k     = r_k;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_di    = r_di;
        n_zero  = r_zero;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_wa   = i_weight_a & WMASK;
                    n_wb   = i_weight_b & WMASK;
                    n_last = i_last_element;
                    // a full vector holds its sums; the flag still closes it
                    if (r_cnt < MAXC) begin
                        n_state = S_E1;
                    end else if (i_last_element) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_E1: begin
                n_abs   = w_sum[ABS_W-1:0];
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_E2;
            end
            S_E2: begin
                n_dot   = w_sum[ACC_W-1:0];
                n_state = S_E3;
            end
            S_E3: begin
                n_na    = w_sum[ACC_W-1:0];
                n_state = S_E4;
            end
            S_E4: begin
                n_nb    = w_sum[ACC_W-1:0];
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                n_li    = '0;
                n_lj    = '0;
                n_acc   = '0;
                n_phase = 1'b0;
                n_c     = '0;
                n_rem   = '0;
                n_quo   = '0;
                n_di    = DI_TOP;
                if (r_na == '0 || r_nb == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_DV;
                end else begin
                    n_zero  = 1'b0;
                    n_state = S_PM;
                end
            end
            S_PM: begin
                n_state = S_PA;
            end
            S_PA: begin
                n_acc   = w_sum;
                n_state = S_PM;
                if (r_lj == L_TOP) begin
                    n_lj = '0;
                    if (r_li == L_TOP) begin
                        n_li  = '0;
                        n_acc = '0;
                        if (!r_phase) begin
                            n_p     = w_sum[PW-1:0];
                            n_phase = 1'b1;
                        end else begin
                            n_d     = SW'(w_sum[PW-1:0]) << COS_SHIFT;
                            n_s     = '0;
                            n_q     = '0;
                            n_k     = K_TOP;
                            n_state = S_C1;
                        end
                    end else begin
                        n_li = r_li + LIW'(1);
                    end
                end else begin
                    n_lj = r_lj + LIW'(1);
                end
            end
            S_C1: begin
                n_t     = w_sum;
                n_state = S_C2;
            end
            S_C2: begin
                n_t     = w_sum;
                n_state = S_C3;
            end
            S_C3: begin
                if (w_carry) begin
                    n_s     = r_t[SW-1:0];
                    n_c     = r_c | (COS_W'(1) << r_k);
                    n_state = S_C4;
                end else if (r_k == '0) begin
                    n_state = S_DV;
                end else begin
                    n_k     = r_k - KW'(1);
                    n_state = S_C1;
                end
            end
            S_C4: begin
                n_q = w_sum[QW-1:0];
                if (r_k == '0) begin
                    n_state = S_DV;
                end else begin
                    n_k     = r_k - KW'(1);
                    n_state = S_C1;
                end
            end
            S_DV: begin
                // restoring division, one quotient bit a cycle
                n_rem = w_carry ? w_sum[CNT_W-1:0] : w_rp[CNT_W-1:0];
                n_quo = {r_quo[ABS_W-2:0], w_carry};
                if (r_di == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_di = r_di - DIW'(1);
                end
            end
            S_OUT: begin
                if (w_space) begin
                    n_dot   = '0;
                    n_na    = '0;
                    n_nb    = '0;
                    n_abs   = '0;
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
            r_abs   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_dot   <= n_dot;
            r_na    <= n_na;
            r_nb    <= n_nb;
            r_abs   <= n_abs;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa    <= n_wa;
        r_wb    <= n_wb;
        r_last  <= n_last;
        r_li    <= n_li;
        r_lj    <= n_lj;
        r_phase <= n_phase;
        r_acc   <= n_acc;
        r_p     <= n_p;
        r_d     <= n_d;
        r_s     <= n_s;
        r_q     <= n_q;
        r_t     <= n_t;
        r_c     <= n_c;
        r_k     <= n_k;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_di    <= n_di;
        r_zero  <= n_zero;
    end

    vs_alu #(
        .W(TW)
    ) u_alu (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_mul_x(w_mul_x),
        .i_mul_y(w_mul_y),
        .i_add_x(w_add_x),
        .i_add_y(w_add_y),
        .o_prod (w_prod),
        .o_sum  (w_sum),
        .o_carry(w_carry)
    );

    vs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_cosine(r_c),
        .i_mean  (r_quo[15:0]),
        .i_zero  (r_zero),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_space (w_space),
        .o_cosine(o_cosine),
        .o_mean  (o_mean_abs_distance),
        .o_zero  (o_zero_norm)
    );

    `VS_ASSERT(a_cos_range, i_clk, i_rst_n, w_load |-> (r_c <= COS_ONE), "cosine above one")
    `VS_NEVER(a_zero_cos, i_clk, i_rst_n, w_load && r_zero && |r_c, "cosine set on zero norm")
    `VS_NEVER(a_rem_below, i_clk, i_rst_n, r_state == S_DV && r_rem >= r_cnt, "remainder too big")
    `VS_NEVER(a_cnt_max, i_clk, i_rst_n, r_cnt > MAXC, "element count beyond maximum length")
    `VS_ASSERT(a_load_shows, i_clk, i_rst_n, w_load |=> o_out_valid, "loaded result not presented")

endmodule

### verif/vector_similarity_test.sv
`timescale 1ns / 1ps

module vector_similarity_test;

    localparam int MAX_LEN        = 4096;
    localparam int W_BITS         = 16;
    localparam int LONG_LEN       = 48;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [15:0] W_MASK = (W_BITS >= 16) ? 16'hFFFF : 16'((1 << W_BITS) - 1);
    localparam logic [15:0] EXTREME_W [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};

    typedef enum int {
        MIX_RANDOM,
        MIX_SMALL,
        MIX_EQUAL,
        MIX_A_ZERO,
        MIX_B_ZERO,
        MIX_EXTREME,
        MIX_NEAR,
        MIX_SCALED
    } t_pair_mix;

    typedef struct packed {
        logic [vs_pkg::COS_W-1:0] cosine;
        logic [15:0]              mean_dist;
        logic                     zero_norm;
    } t_sim_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [15:0] i_weight_a     = '0;
    logic [15:0] i_weight_b     = '0;
    logic        i_last_element = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [vs_pkg::COS_W-1:0] o_cosine;
    logic [15:0] o_mean_abs_distance;
    logic        o_zero_norm;

    // running sums of the open vector pair
    logic [43:0] dot_acc;
    logic [43:0] norm_a_acc;
    logic [43:0] norm_b_acc;
    logic [27:0] abs_diff_acc;
    logic [12:0] elem_count;

    t_sim_result expected_results[$];
    t_sim_result exp_r;

    bit idle_on          = 1'b1;
    int elem_transfers   = 0;
    int vectors_closed   = 0;
    int results_checked  = 0;
    int zero_norm_seen   = 0;
    int mismatches       = 0;
    int unexpected       = 0;
    int reports          = 0;
    int stall_cycles     = 0;

    vector_similarity #(
        .MAX_LENGTH (MAX_LEN),
        .WEIGHT_BITS(W_BITS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_weight_a         (i_weight_a),
        .i_weight_b         (i_weight_b),
        .i_last_element     (i_last_element),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_cosine           (o_cosine),
        .o_mean_abs_distance(o_mean_abs_distance),
        .o_zero_norm        (o_zero_norm)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // largest c in [0, one] with c^2 * na * nb <= dot^2 * 2^30
    function automatic logic [vs_pkg::COS_W-1:0] cosine_q15(input logic [43:0] dot,
                                                            input logic [43:0] na,
                                                            input logic [43:0] nb);
        logic [159:0] prod;
        logic [159:0] rhs;
        logic [159:0] lhs;
        int lo;
        int hi;
        int mid;
        prod = 160'(na) * 160'(nb);
        rhs  = (160'(dot) * 160'(dot)) << vs_pkg::COS_SHIFT;
        lo   = 0;
        hi   = int'(vs_pkg::COS_ONE);
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 160'(mid) * 160'(mid) * prod;
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return vs_pkg::COS_W'(lo);
    endfunction

    task automatic accumulate_element(input logic [15:0] a_in, input logic [15:0] b_in,
                                      input logic last);
        logic [15:0] a;
        logic [15:0] b;
        t_sim_result r;
        a = a_in & W_MASK;
        b = b_in & W_MASK;
        // past the length limit the sums hold, only the closing flag matters
        if (int'(elem_count) < MAX_LEN) begin
            dot_acc      += 44'(a) * 44'(b);
            norm_a_acc   += 44'(a) * 44'(a);
            norm_b_acc   += 44'(b) * 44'(b);
            abs_diff_acc += (a >= b) ? 28'(a - b) : 28'(b - a);
            elem_count   += 13'd1;
        end
        if (last) begin
            if (norm_a_acc == '0 || norm_b_acc == '0) begin
                r.cosine    = '0;
                r.zero_norm = 1'b1;
            end else begin
                r.cosine    = cosine_q15(dot_acc, norm_a_acc, norm_b_acc);
                r.zero_norm = 1'b0;
            end
            r.mean_dist = 16'(abs_diff_acc / 28'(elem_count));
            expected_results.push_back(r);
            vectors_closed++;
            dot_acc      = '0;
            norm_a_acc   = '0;
            norm_b_acc   = '0;
            abs_diff_acc = '0;
            elem_count   = '0;
        end
    endtask

    // valid stays high across back-to-back transfers, it only drops for a gap
    task automatic send_element(input logic [15:0] a, input logic [15:0] b, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_weight_a     <= a;
        i_weight_b     <= b;
        i_last_element <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        elem_transfers++;
        accumulate_element(a, b, last);
    endtask

    function automatic logic [31:0] pair_for_mix(input t_pair_mix mix);
        logic [15:0] a;
        logic [15:0] b;
        int near;
        a = 16'($urandom);
        b = 16'($urandom);
        case (mix)
            MIX_SMALL: begin
                a = 16'($urandom_range(0, 255));
                b = 16'($urandom_range(0, 255));
            end
            MIX_EQUAL: begin
                b = a;
            end
            MIX_A_ZERO: begin
                a = '0;
            end
            MIX_B_ZERO: begin
                b = '0;
            end
            MIX_EXTREME: begin
                a = EXTREME_W[$urandom_range(0, 3)];
                b = EXTREME_W[$urandom_range(0, 3)];
            end
            MIX_NEAR: begin
                near = int'(a) + int'($urandom_range(0, 64)) - 32;
                b = (near < 0) ? 16'h0000 : (near > 65535) ? 16'hFFFF : 16'(near);
            end
            MIX_SCALED: begin
                b = a >> $urandom_range(1, 8);
            end
            default: begin
            end
        endcase
        return {a, b};
    endfunction

    task automatic send_random_vectors(input int n_items, input int max_len);
        int sent;
        int len;
        int r;
        t_pair_mix mix;
        logic [31:0] ab;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                len = $urandom_range(1, (max_len < 8) ? max_len : 8);
            end else if (r < 95) begin
                len = $urandom_range(1, (max_len < 32) ? max_len : 32);
            end else begin
                len = $urandom_range(1, max_len);
            end
            r = $urandom_range(0, 9);
            mix = (r > int'(MIX_SCALED)) ? MIX_RANDOM : t_pair_mix'(r);
            for (int k = 0; k < len; k++) begin
                ab = pair_for_mix(mix);
                send_element(ab[31:16], ab[15:0], k == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_extremes();
        send_element(16'hFFFF, 16'hFFFF, 1'b1);
        send_element(16'h0001, 16'h0001, 1'b1);
        send_element(16'h0001, 16'hFFFF, 1'b1);
        // orthogonal pair, cosine zero without the flag
        send_element(16'hFFFF, 16'h0000, 1'b0);
        send_element(16'h0000, 16'hFFFF, 1'b1);
        send_element(16'h0100, 16'h0200, 1'b0);
        send_element(16'h0300, 16'h0100, 1'b0);
        send_element(16'h8000, 16'h7FFF, 1'b1);
        send_element(16'h5555, 16'hAAAA, 1'b0);
        send_element(16'hAAAA, 16'h5555, 1'b1);
    endtask

    task automatic test_zero_norm();
        send_element(16'h0000, 16'h0000, 1'b1);
        send_element(16'hFFFF, 16'h0000, 1'b1);
        send_element(16'h0000, 16'hFFFF, 1'b1);
        send_element(16'h0000, 16'h0005, 1'b0);
        send_element(16'h0000, 16'h0007, 1'b1);
        send_element(16'h1234, 16'h0000, 1'b0);
        send_element(16'hFEDC, 16'h0000, 1'b0);
        send_element(16'h0000, 16'h0000, 1'b1);
    endtask

    task automatic test_long_vectors();
        logic [31:0] ab;
        // widest per-element sums over a long vector
        for (int k = 0; k < LONG_LEN; k++) begin
            send_element(16'hFFFF, 16'hFFFF, k == LONG_LEN - 1);
        end
        for (int k = 0; k < LONG_LEN; k++) begin
            ab = pair_for_mix(MIX_RANDOM);
            send_element(ab[31:16], ab[15:0], k == LONG_LEN - 1);
        end
    endtask

    task automatic test_random_vectors();
        send_random_vectors(320, 64);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        send_random_vectors(60, 6);
    endtask

    // result side drops ready in random bursts while idle gaps are on
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                unexpected++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $display("unexpected result: cosine %0d mean %0d zero_norm %0b",
                             o_cosine, o_mean_abs_distance, o_zero_norm);
                end
            end else begin
                exp_r = expected_results.pop_front();
                results_checked++;
                if (exp_r.zero_norm) zero_norm_seen++;
                if (o_cosine !== exp_r.cosine || o_mean_abs_distance !== exp_r.mean_dist ||
                    o_zero_norm !== exp_r.zero_norm) begin
                    mismatches++;
                    if (reports < REPORT_LIMIT) begin
                        reports++;
                        $display("result %0d exp/got: cosine %0d/%0d mean %0d/%0d zero %0b/%0b",
                                 results_checked, exp_r.cosine, o_cosine, exp_r.mean_dist,
                                 o_mean_abs_distance, exp_r.zero_norm, o_zero_norm);
                    end
                end
            end
        end
    end

    // a run with no transfer for too long is hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        dot_acc      = '0;
        norm_a_acc   = '0;
        norm_b_acc   = '0;
        abs_diff_acc = '0;
        elem_count   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_zero_norm();
        test_long_vectors();
        test_random_vectors();
        test_back_to_back();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d element transfers over %0d vector pairs, full-scale, zero and random",
                 elem_transfers, vectors_closed);
        $display("%0d results checked (%0d with a zero norm), %0d mismatches, %0d unexpected",
                 results_checked, zero_norm_seen, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/vs_pkg.sv
design/vs_alu.sv
design/vs_out_reg.sv
design/vector_similarity.sv
verif/vector_similarity_test.sv
